// ----- design/w2rgb_pkg.sv -----
`default_nettype none

package w2rgb_pkg;

	// Band edges in units of 1/16 nm
	localparam logic [13:0] WL_380 = 14'd6080;
	localparam logic [13:0] WL_420 = 14'd6720;
	localparam logic [13:0] WL_440 = 14'd7040;
	localparam logic [13:0] WL_490 = 14'd7840;
	localparam logic [13:0] WL_510 = 14'd8160;
	localparam logic [13:0] WL_580 = 14'd9280;
	localparam logic [13:0] WL_645 = 14'd10320;
	localparam logic [13:0] WL_700 = 14'd11200;
	localparam logic [13:0] WL_780 = 14'd12480;

	// Unity in Q16
	localparam int unsigned Q16_ONE = 65536;

	// Colour fraction: floor(x / d) with x < 2^23 and d in {5,15,25,35,65},
	// done as (x * ceil(2^30 / d)) >> 30, exact for this range
	localparam int FRAC_K = 30;
	localparam logic [30:0] FRAC_M5  = 31'((2**30 + 4) / 5);
	localparam logic [30:0] FRAC_M15 = 31'((2**30 + 14) / 15);
	localparam logic [30:0] FRAC_M25 = 31'((2**30 + 24) / 25);
	localparam logic [30:0] FRAC_M35 = 31'((2**30 + 34) / 35);
	localparam logic [30:0] FRAC_M65 = 31'((2**30 + 64) / 65);

	// Intensity: floor(x / 25) with x < 2^22, as (x * ceil(2^27 / 25)) >> 27
	localparam int INT_K = 27;
	localparam logic [22:0] INT_M = 23'((2**27 + 24) / 25);
	localparam logic [21:0] INT_UNITY_X = 22'(Q16_ONE * 25);

	// What drives a colour channel
	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_FRAC,
		SRC_ONE
	} chan_src_t;

	typedef struct packed {
		chan_src_t r;
		chan_src_t g;
		chan_src_t b;
	} chan_sel_t;

endpackage

`default_nettype wire

// ----- design/wavelength_to_rgb_core.sv -----
// Throughput: one wavelength per cycle while the output is not stalled.
// Four register stages (decode, divide by reciprocal multiply, intensity multiply,
// scale by 255) each hold one item.
// Output stall holds the last stage; bubbles in earlier stages still close up.
// Reset (arst_n low, asynchronous) clears the stage valid bits; data is not reset.
`default_nettype none

module wavelength_to_rgb_core
	import w2rgb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [13:0] wavelength,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	// 255 * v >> 32 for the channel source
	function automatic logic [7:0] chan_out(chan_src_t src, logic [33:0] p, logic [16:0] i);
		logic [33:0] v;
		logic [41:0] s;
		begin
			unique case (src)
				SRC_FRAC: v = p;
				SRC_ONE:  v = 34'({i, 16'h0000});
				default:  v = '0;
			endcase
			s = {v, 8'h00} - 42'(v);
			return s[39:32];
		end
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// Stage enables: a stage loads when it is empty or its successor moves
	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	// Decode band, form the dividends and pick the reciprocal
	logic [22:0] frac_x;
	logic [30:0] frac_m;
	logic [21:0] int_x;
	logic [13:0] int_n;
	chan_sel_t   sel;

	always_comb begin
		frac_x = '0;
		frac_m = FRAC_M5;
		int_x  = '0;
		int_n  = '0;
		sel    = '{r: SRC_ZERO, g: SRC_ZERO, b: SRC_ZERO};
		priority if (wavelength >= WL_380 && wavelength < WL_440) begin
			frac_x = 23'(WL_440 - wavelength) << 10;
			frac_m = FRAC_M15;
			sel    = '{r: SRC_FRAC, g: SRC_ZERO, b: SRC_ONE};
		end else if (wavelength >= WL_440 && wavelength < WL_490) begin
			frac_x = 23'(wavelength - WL_440) << 11;
			frac_m = FRAC_M25;
			sel    = '{r: SRC_ZERO, g: SRC_FRAC, b: SRC_ONE};
		end else if (wavelength >= WL_490 && wavelength < WL_510) begin
			frac_x = 23'(WL_510 - wavelength) << 10;
			frac_m = FRAC_M5;
			sel    = '{r: SRC_ZERO, g: SRC_ONE, b: SRC_FRAC};
		end else if (wavelength >= WL_510 && wavelength < WL_580) begin
			frac_x = 23'(wavelength - WL_510) << 11;
			frac_m = FRAC_M35;
			sel    = '{r: SRC_FRAC, g: SRC_ONE, b: SRC_ZERO};
		end else if (wavelength >= WL_580 && wavelength < WL_645) begin
			frac_x = 23'(WL_645 - wavelength) << 12;
			frac_m = FRAC_M65;
			sel    = '{r: SRC_ONE, g: SRC_FRAC, b: SRC_ZERO};
		end else if (wavelength >= WL_645 && wavelength <= WL_780) begin
			sel    = '{r: SRC_ONE, g: SRC_ZERO, b: SRC_ZERO};
		end else begin
			sel    = '{r: SRC_ZERO, g: SRC_ZERO, b: SRC_ZERO};
		end

		// Intensity ramps scaled so both divide by 25
		priority if (wavelength >= WL_380 && wavelength < WL_420) begin
			int_n = 14'd1920 + 14'd7 * (wavelength - WL_380);
			int_x = 22'(int_n) << 8;
		end else if (wavelength >= WL_420 && wavelength <= WL_700) begin
			int_x = INT_UNITY_X;
		end else if (wavelength > WL_700 && wavelength <= WL_780) begin
			int_n = 14'd3840 + 14'd7 * (WL_780 - wavelength);
			int_x = 22'(int_n) << 7;
		end else begin
			int_x = '0;
		end
	end

	logic [22:0] frac_x_s1;
	logic [30:0] frac_m_s1;
	logic [21:0] int_x_s1;
	chan_sel_t   sel_s1, sel_s2, sel_s3;
	logic [16:0] frac_s2, inten_s2, inten_s3;
	logic [33:0] prod_s3;
	logic [53:0] frac_prod;
	logic [44:0] int_prod;

	// Valid bits advance with their stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: hold decoded operands
	always_ff @(posedge clk) begin
		if (en1) begin
			frac_x_s1 <= frac_x;
			frac_m_s1 <= frac_m;
			int_x_s1  <= int_x;
			sel_s1    <= sel;
		end
	end

	// Stage 2: divide by constant through reciprocal multiply
	assign frac_prod = 54'(frac_x_s1) * 54'(frac_m_s1);
	assign int_prod  = 45'(int_x_s1) * 45'(INT_M);

	always_ff @(posedge clk) begin
		if (en2) begin
			frac_s2  <= 17'(frac_prod >> FRAC_K);
			inten_s2 <= 17'(int_prod >> INT_K);
			sel_s2   <= sel_s1;
		end
	end

	// Stage 3: apply intensity to the colour fraction
	always_ff @(posedge clk) begin
		if (en3) begin
			prod_s3  <= 34'(inten_s2) * 34'(frac_s2);
			inten_s3 <= inten_s2;
			sel_s3   <= sel_s2;
		end
	end

	// Stage 4: scale to 8 bits and hold for the output transfer
	always_ff @(posedge clk) begin
		if (en4) begin
			red   <= chan_out(sel_s3.r, prod_s3, inten_s3);
			green <= chan_out(sel_s3.g, prod_s3, inten_s3);
			blue  <= chan_out(sel_s3.b, prod_s3, inten_s3);
		end
	end

	assign out_valid = v_s4;

endmodule

`default_nettype wire

// ----- design/w2rgb_checker.sv -----
`default_nettype none

module w2rgb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [13:0] wavelength,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  red,
	input wire logic [7:0]  green,
	input wire logic [7:0]  blue
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({red, green, blue}))
		else $error("result changed while stalled");

	// Input is only back-pressured when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// An accepted item appears at the output when the output does not stall while it passes the stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

	// With no input and no stall the pipeline drains
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_valid && !out_stall) ##1 (!in_valid && !out_stall) ##1
		(!in_valid && !out_stall) ##1 (!in_valid && !out_stall) |=> !out_valid)
		else $error("result appeared without an input");

endmodule

bind wavelength_to_rgb_core w2rgb_checker u_w2rgb_checker (.*);

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import w2rgb_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLDOFF_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 200;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [13:0] wavelength = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	logic [13:0] wl_backlog[$];
	colour_t     colour_due[$];
	int          queued_cnt = 0;
	int          accepted_cnt = 0;
	int          mismatches = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	bit          holdoff_req = 1'b0;
	bit          in_done = 1'b0;

	wavelength_to_rgb_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.wavelength (wavelength),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always #2 clk = ~clk;

	// floor(num * 2^16 / den)
	function automatic longint unsigned q16_div(longint unsigned num, longint unsigned den);
		return (num << 16) / den;
	endfunction

	// Scale intensity times fraction to 8 bits, truncating
	function automatic logic [7:0] scale_255(longint unsigned inten, longint unsigned frac);
		longint unsigned v;
		v = (64'd255 * inten * frac) >> 32;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// Map one wavelength to the display colour it should produce
	function automatic colour_t spectrum_colour(logic [13:0] wl);
		longint unsigned w;
		longint unsigned fr;
		longint unsigned fg;
		longint unsigned fb;
		longint unsigned inten;
		colour_t c;
		w = wl;
		fr = 0;
		fg = 0;
		fb = 0;
		inten = 0;
		// colour fraction per band
		if (w >= WL_380 && w < WL_440) begin
			fr = q16_div(WL_440 - w, WL_440 - WL_380);
			fb = Q16_ONE;
		end else if (w >= WL_440 && w < WL_490) begin
			fg = q16_div(w - WL_440, WL_490 - WL_440);
			fb = Q16_ONE;
		end else if (w >= WL_490 && w < WL_510) begin
			fg = Q16_ONE;
			fb = q16_div(WL_510 - w, WL_510 - WL_490);
		end else if (w >= WL_510 && w < WL_580) begin
			fr = q16_div(w - WL_510, WL_580 - WL_510);
			fg = Q16_ONE;
		end else if (w >= WL_580 && w < WL_645) begin
			fr = Q16_ONE;
			fg = q16_div(WL_645 - w, WL_645 - WL_580);
		end else if (w >= WL_645 && w <= WL_780) begin
			fr = Q16_ONE;
		end
		// intensity roll-off at both ends of the visible range
		if (w >= WL_380 && w < WL_420) begin
			inten = q16_div(1920 + 7 * (w - WL_380), 6400);
		end else if (w >= WL_420 && w <= WL_700) begin
			inten = Q16_ONE;
		end else if (w > WL_700 && w <= WL_780) begin
			inten = q16_div(3840 + 7 * (WL_780 - w), 12800);
		end
		c.red   = scale_255(inten, fr);
		c.green = scale_255(inten, fg);
		c.blue  = scale_255(inten, fb);
		return c;
	endfunction

	// Mostly visible-range wavelengths, some anywhere in the field
	function automatic logic [13:0] pick_wavelength();
		if ($urandom_range(9) < 7)
			return 14'($urandom_range(12600, 6000));
		return 14'($urandom);
	endfunction

	task automatic offer(logic [13:0] w);
		wl_backlog.push_back(w);
		queued_cnt++;
	endtask

	// Hold the sender until every queued wavelength has produced its colour
	task automatic drain();
		while (accepted_cnt != queued_cnt || colour_due.size() != 0)
			@(negedge clk);
	endtask

	// Present wavelengths; hold the payload while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_done) begin
			if (wl_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				wavelength <= wl_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
				wavelength <= 14'($urandom);
			end
		end
	end

	// Stall the output at random, or for a long hold-off on request
	always @(negedge clk) begin
		if (holdoff_req) begin
			hold_left = HOLDOFF_CYCLES;
			holdoff_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Check each output transfer, then record each input transfer
	always @(posedge clk) begin
		colour_t got;
		colour_t want;
		in_done = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{red, green, blue};
				if (colour_due.size() == 0) begin
					$display("%0t: unexpected colour r=%0d g=%0d b=%0d",
						$time, red, green, blue);
					mismatches++;
				end else begin
					want = colour_due.pop_front();
					if (got.red !== want.red) begin
						$display("%0t: red expected %0d got %0d", $time, want.red, got.red);
						mismatches++;
					end
					if (got.green !== want.green) begin
						$display("%0t: green expected %0d got %0d",
							$time, want.green, got.green);
						mismatches++;
					end
					if (got.blue !== want.blue) begin
						$display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				colour_due.push_back(spectrum_colour(wavelength));
				accepted_cnt++;
				in_done = 1'b1;
			end
		end
	end

	// End the run if no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [13:0] edges[$];
		edges = '{14'd0, 14'd16383, 14'd6079, 14'd6080, 14'd6719, 14'd6720,
			14'd7039, 14'd7040, 14'd7839, 14'd7840, 14'd8159, 14'd8160,
			14'd9279, 14'd9280, 14'd10319, 14'd10320, 14'd11199, 14'd11200,
			14'd11201, 14'd12479, 14'd12480, 14'd12481, 14'd8720};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// band edges, range limits and all-ones/all-zeros
		foreach (edges[i])
			offer(edges[i]);
		drain();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = (ph == 1) ? 60 : (ph == 3) ? 34 : 0;
			rx_idle_pct = (ph == 2) ? 60 : (ph == 3) ? 34 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				offer(pick_wavelength());
				// pause the sender mid-phase until the pipeline is empty
				if (ph == 3 && i == RANDOM_PER_PHASE / 2)
					drain();
			end
			drain();
		end

		// long receiver hold-off while the sender keeps offering
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		holdoff_req = 1'b1;
		for (int i = 0; i < 40; i++)
			offer(pick_wavelength());
		drain();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
